// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file bc_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define BC_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// shorthand for modules that use clk and arst_n
`define BC_ASSERT(lbl, prop, msg) `BC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ----- hw/rtl/bc_pkg.sv -----
// shared types, constants and helpers of the barometric compensation core
// no dependencies
package bc_pkg;

	localparam int DATA_W          = 32;
	localparam int CFG_IDX_W       = 3;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [31:0] B5_OFFSET = 32'd4000;
	localparam logic [31:0] P_C1      = 32'd3038;
	localparam logic [31:0] P_C2      = 32'hFFFF_E343;
	localparam logic [31:0] P_C3      = 32'd3791;
	localparam logic [31:0] OSS_BASE  = 32'd50000;
	localparam logic [31:0] B4_BIAS   = 32'd32768;
	localparam logic [31:0] T_ROUND   = 32'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AC1  = 3'd0,
		REG_AC2  = 3'd1,
		REG_AC3  = 3'd2,
		REG_AC4  = 3'd3,
		REG_TGO  = 3'd4,
		REG_TCRV = 3'd5,
		REG_B1   = 3'd6,
		REG_B2   = 3'd7
	} bc_reg_t;

	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] mc;
		logic [15:0] md;
		logic [15:0] b1;
		logic [15:0] b2;
	} bc_cal_t;

	localparam bc_cal_t CAL_RESET = '{
		ac1: 16'd408,
		ac2: 16'hFFB8,
		ac3: 16'hC7D1,
		ac4: 16'd32741,
		ac5: 16'h7FF5,
		ac6: 16'h5A71,
		mc:  16'hDDF9,
		md:  16'h0B34,
		b1:  16'd6190,
		b2:  16'd4
	};

	// one beat handed from the temperature side to the pressure side
	typedef struct packed {
		logic [31:0] temperature;
		logic [31:0] b5;
		logic [18:0] up;
		logic [1:0]  oss;
		logic        fault;
	} bc_entry_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
		logic [31:0] r;
		r = 32'($signed(v) >>> s);
		return r;
	endfunction

endpackage

// ----- hw/rtl/bc_udiv.sv -----
// pipelined 32-bit unsigned restoring divider, one quotient bit per stage
// uses bc_pkg for the data width
module bc_udiv #(
	parameter int TAG_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [bc_pkg::DATA_W-1:0] in_num,
	input  logic [bc_pkg::DATA_W-1:0] in_den,
	input  logic [TAG_W-1:0]          in_tag,
	output logic                      out_valid,
	output logic [bc_pkg::DATA_W-1:0] out_quo,
	output logic [TAG_W-1:0]          out_tag
);
	import bc_pkg::*;

	logic              vld_q [1:DATA_W];
	logic [DATA_W-1:0] rem_q [1:DATA_W];
	logic [DATA_W-1:0] nq_q  [1:DATA_W];
	logic [DATA_W-1:0] den_q [1:DATA_W];
	logic [TAG_W-1:0]  tag_q [1:DATA_W];

	for (genvar k = 0; k < DATA_W; k++) begin : g_stage
		logic              v_in;
		logic [DATA_W-1:0] r_in, n_in, d_in;
		logic [TAG_W-1:0]  t_in;
		logic [DATA_W:0]   sh, diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = '0;
			assign n_in = in_num;
			assign d_in = in_den;
			assign t_in = in_tag;
		end else begin : g_rest
			assign v_in = vld_q[k];
			assign r_in = rem_q[k];
			assign n_in = nq_q[k];
			assign d_in = den_q[k];
			assign t_in = tag_q[k];
		end

		// shift in the next numerator bit, subtract when it fits
		assign sh   = {r_in, n_in[DATA_W-1]};
		assign ge   = sh >= {1'b0, d_in};
		assign diff = sh - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[k+1] <= 1'b0;
			else         vld_q[k+1] <= v_in;
		end

		always_ff @(posedge clk) begin
			rem_q[k+1] <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
			nq_q[k+1]  <= {n_in[DATA_W-2:0], ge};
			den_q[k+1] <= d_in;
			tag_q[k+1] <= t_in;
		end
	end

	assign out_valid = vld_q[DATA_W];
	assign out_quo   = nq_q[DATA_W];
	assign out_tag   = tag_q[DATA_W];

endmodule

// ----- hw/rtl/bc_front.sv -----
// temperature side: accepts readings, computes B5 and temperature
// uses bc_pkg and bc_udiv
module bc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [15:0]       raw_temperature,
	input  logic [18:0]       raw_pressure,
	input  logic [1:0]        oversampling,
	input  bc_pkg::bc_cal_t   cal,
	output logic              push,
	output bc_pkg::bc_entry_t entry
);
	import bc_pkg::*;

	typedef struct packed {
		logic [31:0] x1;
		logic        neg;
		logic        zero;
		logic [18:0] up;
		logic [1:0]  oss;
	} ftag_t;

	logic        vld_s1, vld_s2;
	logic [31:0] x1m_s1, x1_s2, d_s2;
	logic [18:0] up_s1, up_s2;
	logic [1:0]  oss_s1, oss_s2;

	logic [31:0] ut_diff, num, un, ud, q, x2, b5;
	ftag_t       tag_in, tag_out;
	logic        dv;

	assign ut_diff = {16'h0, raw_temperature} - {16'h0, cal.ac6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			push   <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			push   <= dv;
		end
	end

	always_ff @(posedge clk) begin
		x1m_s1 <= ut_diff * {16'h0, cal.ac5};
		up_s1  <= raw_pressure;
		oss_s1 <= oversampling;
		x1_s2  <= asr(x1m_s1, 15);
		d_s2   <= asr(x1m_s1, 15) + sx16(cal.md);
		up_s2  <= up_s1;
		oss_s2 <= oss_s1;
	end

	// signed divide by magnitudes, sign restored after the divider
	assign num = sx16(cal.mc) << 11;
	assign un  = num[31] ? (32'h0 - num) : num;
	assign ud  = d_s2[31] ? (32'h0 - d_s2) : d_s2;

	always_comb begin
		tag_in.x1   = x1_s2;
		tag_in.neg  = num[31] ^ d_s2[31];
		tag_in.zero = (d_s2 == 32'h0);
		tag_in.up   = up_s2;
		tag_in.oss  = oss_s2;
	end

	bc_udiv #(.TAG_W($bits(ftag_t))) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_num    (un),
		.in_den    (ud),
		.in_tag    (tag_in),
		.out_valid (dv),
		.out_quo   (q),
		.out_tag   (tag_out)
	);

	assign x2 = tag_out.neg ? (32'h0 - q) : q;
	assign b5 = tag_out.x1 + x2;

	always_ff @(posedge clk) begin
		entry.temperature <= tag_out.zero ? 32'h0 : asr(b5 + T_ROUND, 4);
		entry.b5          <= b5;
		entry.up          <= tag_out.up;
		entry.oss         <= tag_out.oss;
		entry.fault       <= tag_out.zero;
	end

endmodule

// ----- hw/rtl/bc_queue.sv -----
// short queue between the temperature and pressure sides
// uses bc_pkg for the entry type
module bc_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bc_pkg::bc_entry_t din,
	output logic              out_valid,
	output bc_pkg::bc_entry_t dout
);
	import bc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bc_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	// the pressure side never stalls, so the head leaves as soon as it shows
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule

// ----- hw/rtl/bc_back.sv -----
// pressure side: B6..B7, pressure divide and final correction
// uses bc_pkg and bc_udiv
module bc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bc_pkg::bc_entry_t in_entry,
	input  bc_pkg::bc_cal_t   cal,
	output logic              done,
	output logic [31:0]       temperature,
	output logic [31:0]       pressure,
	output logic              div_fault
);
	import bc_pkg::*;

	typedef struct packed {
		logic [31:0] t;
		logic        fault;
		logic        split;
	} btag_t;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [31:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic        f_s1, f_s2, f_s3, f_s4, f_s5, f_s6, f_s7;
	logic [18:0] up_s1, up_s2, up_s3, up_s4;
	logic [1:0]  oss_s1, oss_s2, oss_s3, oss_s4;
	logic [31:0] b6_s1, sqm_s2, m2_s2, m3_s2;
	logic [31:0] mb2_s3, mb1_s3, x2_s3, x1c_s3;
	logic [31:0] b3_s4, x3_s4, b4_s5, b7_s5;
	logic [31:0] p_s6, x1sq_s6, x2m_s6, p_s7, x1m_s7, x2_s7;

	logic [31:0] sq, x3a, b3_pre, x3b, num, q, p, px, x1f;
	btag_t       tag_in, tag_out;
	logic        dv;

	assign sq     = asr(sqm_s2, 12);
	assign x3a    = asr(mb2_s3, 11) + x2_s3;
	assign b3_pre = ((sx16(cal.ac1) << 2) + x3a) << oss_s3;
	assign x3b    = asr(x1c_s3 + asr(mb1_s3, 16) + 32'd2, 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= dv;
			vld_s7 <= vld_s6;
			done   <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		b6_s1  <= in_entry.b5 - B5_OFFSET;
		t_s1   <= in_entry.temperature;
		f_s1   <= in_entry.fault;
		up_s1  <= in_entry.up;
		oss_s1 <= in_entry.oss;

		sqm_s2 <= b6_s1 * b6_s1;
		m2_s2  <= sx16(cal.ac2) * b6_s1;
		m3_s2  <= sx16(cal.ac3) * b6_s1;
		t_s2   <= t_s1;
		f_s2   <= f_s1;
		up_s2  <= up_s1;
		oss_s2 <= oss_s1;

		mb2_s3 <= sx16(cal.b2) * sq;
		mb1_s3 <= sx16(cal.b1) * sq;
		x2_s3  <= asr(m2_s2, 11);
		x1c_s3 <= asr(m3_s2, 13);
		t_s3   <= t_s2;
		f_s3   <= f_s2;
		up_s3  <= up_s2;
		oss_s3 <= oss_s2;

		b3_s4  <= asr(b3_pre + 32'd2, 2);
		x3_s4  <= x3b;
		t_s4   <= t_s3;
		f_s4   <= f_s3;
		up_s4  <= up_s3;
		oss_s4 <= oss_s3;

		b4_s5  <= ({16'h0, cal.ac4} * (x3_s4 + B4_BIAS)) >> 15;
		b7_s5  <= ({13'h0, up_s4} - b3_s4) * (OSS_BASE >> oss_s4);
		t_s5   <= t_s4;
		f_s5   <= f_s4;
	end

	// below 2^31 the doubled B7 is divided, at or above it the quotient is doubled
	assign num = b7_s5[31] ? b7_s5 : (b7_s5 << 1);

	always_comb begin
		tag_in.t     = t_s5;
		tag_in.fault = f_s5 | (b4_s5 == 32'h0);
		tag_in.split = b7_s5[31];
	end

	bc_udiv #(.TAG_W($bits(btag_t))) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_num    (num),
		.in_den    (b4_s5),
		.in_tag    (tag_in),
		.out_valid (dv),
		.out_quo   (q),
		.out_tag   (tag_out)
	);

	assign p   = tag_out.split ? (q << 1) : q;
	assign px  = asr(p, 8);
	assign x1f = asr(x1m_s7, 16);

	always_ff @(posedge clk) begin
		p_s6    <= p;
		x1sq_s6 <= px * px;
		x2m_s6  <= P_C2 * p;
		t_s6    <= tag_out.t;
		f_s6    <= tag_out.fault;

		p_s7    <= p_s6;
		x1m_s7  <= x1sq_s6 * P_C1;
		x2_s7   <= asr(x2m_s6, 16);
		t_s7    <= t_s6;
		f_s7    <= f_s6;

		temperature <= t_s7;
		pressure    <= f_s7 ? 32'h0 : p_s7 + asr(x1f + x2_s7 + P_C3, 4);
		div_fault   <= f_s7;
	end

endmodule

// ----- hw/rtl/barometric_compensation_core.sv -----
// Barometric compensation core. Takes one raw temperature, raw pressure and
// oversampling setting per beat (start while busy is low) and returns the
// compensated temperature (0.1 degC) and pressure (Pa) on a one-cycle done
// strobe that cannot be held off. A new reading is taken every clock cycle
// while busy is low; each result passes the two 32-stage pipelined dividers
// (temperature and pressure) and the multiply stages around them. busy is
// high in reset and in the cycle after it. A zero divisor raises div_fault
// and forces the affected outputs to zero. The user must write calibration
// words via cfg_we/cfg_index/cfg_data only while idle; the core does not check.
// depends on bc_pkg, bc_front, bc_queue, bc_back
module barometric_compensation_core #(
	parameter int QUEUE_DEPTH = bc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bc_pkg::DATA_W-1:0]    cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [15:0]                  raw_temperature,
	input  logic [18:0]                  raw_pressure,
	input  logic [1:0]                   oversampling,
	output logic                         done,
	output logic signed [31:0]           temperature,
	output logic signed [31:0]           pressure,
	output logic                         div_fault
);
	import bc_pkg::*;

	bc_cal_t   cal_q;
	logic      busy_q;
	logic      push, q_valid;
	bc_entry_t f_entry, q_entry;
	logic [31:0] t_raw, p_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q  <= CAL_RESET;
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				case (bc_reg_t'(cfg_index))
					REG_AC1:  cal_q.ac1 <= cfg_data[15:0];
					REG_AC2:  cal_q.ac2 <= cfg_data[15:0];
					REG_AC3:  cal_q.ac3 <= cfg_data[15:0];
					REG_AC4:  cal_q.ac4 <= cfg_data[15:0];
					REG_TGO:  {cal_q.ac5, cal_q.ac6} <= cfg_data;
					REG_TCRV: {cal_q.mc, cal_q.md} <= cfg_data;
					REG_B1:   cal_q.b1 <= cfg_data[15:0];
					REG_B2:   cal_q.b2 <= cfg_data[15:0];
					default:  ;
				endcase
			end
		end
	end

	assign busy = busy_q;

	bc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (start & ~busy_q),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.oversampling    (oversampling),
		.cal             (cal_q),
		.push            (push),
		.entry           (f_entry)
	);

	bc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (f_entry),
		.out_valid (q_valid),
		.dout      (q_entry)
	);

	bc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_valid),
		.in_entry    (q_entry),
		.cal         (cal_q),
		.done        (done),
		.temperature (t_raw),
		.pressure    (p_raw),
		.div_fault   (div_fault)
	);

	assign temperature = $signed(t_raw);
	assign pressure    = $signed(p_raw);

endmodule

// ----- hw/rtl/bc_checker.sv -----
// port-level checks on the barometric compensation core, bound to the top
// uses assert_macros.svh
module bc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [31:0] temperature,
	input logic [31:0] pressure,
	input logic        div_fault
);
	`include "assert_macros.svh"

	// a faulted beat never carries a pressure value
	`BC_ASSERT(a_fault_zero_p, done && div_fault |-> pressure == 32'h0, "fault with pressure")
	// once out of reset the core stays ready
	`BC_ASSERT(a_busy_stays_low, !busy |=> !busy, "busy rose after reset")
	// nothing can be in flight while busy
	`BC_ASSERT(a_no_done_busy, busy |-> !done, "result while busy")
	// a nonzero temperature means its divisor was fine, so no fault on temperature
	`BC_ASSERT(a_t_valid, done && div_fault && temperature != 32'h0 |-> pressure == 32'h0, "bad fault beat")

endmodule

bind barometric_compensation_core bc_checker u_bc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.done        (done),
	.temperature (temperature),
	.pressure    (pressure),
	.div_fault   (div_fault)
);

// ----- tb/sv/barometric_compensation_checker.sv -----
`timescale 1ns / 1ps
// checker for the barometric compensation core: predicts each result from the
// accepted readings and the calibration words, compares them in order
// depends on bc_pkg
module barometric_compensation_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bc_pkg::DATA_W-1:0]    cfg_data,
	input  logic                         start,
	input  logic                         busy,
	input  logic [15:0]                  raw_temperature,
	input  logic [18:0]                  raw_pressure,
	input  logic [1:0]                   oversampling,
	input  logic                         done,
	input  logic signed [31:0]           temperature,
	input  logic signed [31:0]           pressure,
	input  logic                         div_fault,
	output int                           fail_count,
	output int                           pending
);
	import bc_pkg::*;

	typedef struct packed {
		logic [31:0] temperature;
		logic [31:0] pressure;
		logic        fault;
	} comp_t;

	logic [15:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_b1, cal_b2;
	logic [31:0] cal_tgo, cal_tcrv;
	comp_t readings_due[$];

	function automatic logic [31:0] ext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sra(input logic [31:0] v, input int s);
		return 32'($signed(v) >>> s);
	endfunction

	// signed quotient truncating toward zero, wraps for most negative / -1
	function automatic logic [31:0] quot(input logic [31:0] n, input logic [31:0] d);
		logic [31:0] un, ud, q;
		un = n[31] ? -n : n;
		ud = d[31] ? -d : d;
		q = un / ud;
		return (n[31] != d[31]) ? -q : q;
	endfunction

	function automatic comp_t compensate(input logic [15:0] ut, input logic [18:0] up,
			input logic [1:0] oss);
		comp_t r;
		logic [31:0] c5, c6, mc, md, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, d;
		r = '0;
		c5 = {16'h0, cal_tgo[31:16]};
		c6 = {16'h0, cal_tgo[15:0]};
		mc = ext16(cal_tcrv[31:16]);
		md = ext16(cal_tcrv[15:0]);
		x1 = sra(({16'h0, ut} - c6) * c5, 15);
		d = x1 + md;
		if (d == 0) begin
			r.fault = 1'b1;
			return r;
		end
		x2 = quot(mc * 32'd2048, d);
		b5 = x1 + x2;
		r.temperature = sra(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		sq = sra(b6 * b6, 12);
		x1 = sra(ext16(cal_b2) * sq, 11);
		x2 = sra(ext16(cal_ac2) * b6, 11);
		x3 = x1 + x2;
		b3 = sra(((ext16(cal_ac1) * 32'd4 + x3) << oss) + 32'd2, 2);
		x1 = sra(ext16(cal_ac3) * b6, 13);
		x2 = sra(ext16(cal_b1) * sq, 16);
		x3 = sra(x1 + x2 + 32'd2, 2);
		b4 = ({16'h0, cal_ac4} * (x3 + 32'd32768)) >> 15;
		b7 = ({13'h0, up} - b3) * (32'd50000 >> oss);
		if (b4 == 0) begin
			r.fault = 1'b1;
			return r;
		end
		if (!b7[31])
			p = (b7 * 32'd2) / b4;
		else
			p = (b7 / b4) * 32'd2;
		x1 = sra(p, 8);
		x1 = x1 * x1;
		x1 = sra(x1 * 32'd3038, 16);
		x2 = sra(-32'd7357 * p, 16);
		r.pressure = p + sra(x1 + x2 + 32'd3791, 4);
		return r;
	endfunction

	assign pending = readings_due.size();

	always @(posedge clk or negedge arst_n) begin
		comp_t want;
		if (!arst_n) begin
			cal_ac1 <= 16'd408;
			cal_ac2 <= 16'hFFB8;
			cal_ac3 <= 16'hC7D1;
			cal_ac4 <= 16'd32741;
			cal_tgo <= 32'd2146785905;
			cal_tcrv <= 32'd3724086068;
			cal_b1 <= 16'd6190;
			cal_b2 <= 16'd4;
			fail_count <= 0;
			readings_due.delete();
		end else begin
			if (start && !busy)
				readings_due.push_back(compensate(raw_temperature, raw_pressure, oversampling));
			if (done) begin
				if (readings_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat t=%0d p=%0d f=%0b",
							temperature, pressure, div_fault);
					fail_count <= fail_count + 1;
				end else begin
					want = readings_due.pop_front();
					if (want.temperature !== temperature || want.pressure !== pressure
							|| want.fault !== div_fault) begin
						if (fail_count < 10)
							$display("mismatch: exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
								$signed(want.temperature), $signed(want.pressure), want.fault,
								temperature, pressure, div_fault);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) begin
				case (bc_reg_t'(cfg_index))
					REG_AC1:  cal_ac1 <= cfg_data[15:0];
					REG_AC2:  cal_ac2 <= cfg_data[15:0];
					REG_AC3:  cal_ac3 <= cfg_data[15:0];
					REG_AC4:  cal_ac4 <= cfg_data[15:0];
					REG_TGO:  cal_tgo <= cfg_data;
					REG_TCRV: cal_tcrv <= cfg_data;
					REG_B1:   cal_b1 <= cfg_data[15:0];
					REG_B2:   cal_b2 <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- tb/sv/barometric_compensation_core_tb.sv -----
`timescale 1ns / 1ps
// top of the barometric compensation core testbench: clock, reset, calibration
// writes and reading stimulus; depends on bc_pkg, barometric_compensation_core and its checker
module barometric_compensation_core_tb;
	import bc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	logic                 start;
	logic                 busy;
	logic [15:0]          raw_temperature;
	logic [18:0]          raw_pressure;
	logic [1:0]           oversampling;
	logic                 done;
	logic signed [31:0]   temperature;
	logic signed [31:0]   pressure;
	logic                 div_fault;
	int                   fail_count;
	int                   pending;
	int                   cycle_count = 0;
	int                   idle_pct;

	barometric_compensation_core dut (.*);
	barometric_compensation_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("barometric_compensation_core verification failed");
			$finish;
		end
	end

	task automatic write_cal(input bc_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one reading beat, held until accepted, with a random gap first
	task automatic send_reading(input logic [15:0] ut, input logic [18:0] up,
			input logic [1:0] oss);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		raw_temperature <= ut;
		raw_pressure <= up;
		oversampling <= oss;
		// busy only moves at rising edges, so the falling edge shows its value at the next one
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// plausible calibration near the factory values, or fully random words
	task automatic random_cal(input bit wild);
		write_cal(REG_AC1, wild ? $urandom : $urandom_range(1000) - 500 + 408);
		write_cal(REG_AC2, wild ? $urandom : $urandom_range(400) - 272);
		write_cal(REG_AC3, wild ? $urandom : $urandom_range(4000) - 16383);
		write_cal(REG_AC4, wild ? $urandom : $urandom_range(34000, 30000));
		write_cal(REG_TGO, wild ? $urandom : {16'($urandom_range(34000, 30000)),
			16'($urandom_range(24000, 20000))});
		write_cal(REG_TCRV, wild ? $urandom : {16'(-$urandom_range(12000, 8000)),
			16'($urandom_range(3200, 2400))});
		write_cal(REG_B1, wild ? $urandom : $urandom_range(7000, 5000));
		write_cal(REG_B2, wild ? $urandom : $urandom_range(60));
	endtask

	initial begin
		idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		raw_temperature = '0;
		raw_pressure = '0;
		oversampling = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes at reset calibration
		send_reading(16'd0, 19'd0, 2'd0);
		send_reading(16'hFFFF, 19'h7FFFF, 2'd3);
		send_reading(16'd27898, 19'd23843, 2'd0);
		send_reading(16'd27898, 19'd23843, 2'd1);
		send_reading(16'd27898, 19'd95372, 2'd2);
		send_reading(16'd27898, 19'd190000, 2'd3);
		send_reading(16'h5A71, 19'h40000, 2'd1);
		drain();
		// temperature divisor zero: c5 = 0 so x1 = 0, md = 0
		write_cal(REG_TGO, 32'h0000_1234);
		write_cal(REG_TCRV, 32'h8000_0000);
		send_reading(16'd100, 19'd1000, 2'd0);
		drain();
		// negative numerator over a divisor of minus one
		write_cal(REG_TCRV, 32'hFFF0_FFFF);
		send_reading(16'd7, 19'd5000, 2'd2);
		drain();
		// pressure divisor zero via ac4 = 0
		write_cal(REG_TGO, 32'd2146785905);
		write_cal(REG_TCRV, 32'd3724086068);
		write_cal(REG_AC4, 32'd0);
		send_reading(16'd27898, 19'd23843, 2'd0);
		drain();
		// register extremes
		write_cal(REG_AC1, 32'h8000);
		write_cal(REG_AC2, 32'h7FFF);
		write_cal(REG_AC3, 32'h8000);
		write_cal(REG_AC4, 32'hFFFF);
		write_cal(REG_TGO, 32'hFFFF_FFFF);
		write_cal(REG_TCRV, 32'h7FFF_8000);
		write_cal(REG_B1, 32'h7FFF);
		write_cal(REG_B2, 32'h8000);
		send_reading(16'hFFFF, 19'h7FFFF, 2'd3);
		send_reading(16'd0, 19'd0, 2'd0);
		send_reading(16'h8000, 19'h40000, 2'd1);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			random_cal(phase % 4 == 3);
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 47;
				2: idle_pct = 7;
				default: idle_pct = 47;
			endcase
			for (int n = 0; n < 128; n++) begin
				if ($urandom_range(3) != 0)
					send_reading(16'($urandom_range(32000, 20000)),
						19'($urandom_range(200000, 15000)), 2'($urandom_range(3)));
				else
					send_reading(16'($urandom), 19'($urandom), 2'($urandom));
			end
			drain();
		end

		if (fail_count == 0)
			$display("barometric_compensation_core verification clean");
		else
			$display("barometric_compensation_core verification failed");
		$finish;
	end
endmodule
